[hdl/cmsp_pkg.sv]
package cmsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TOKEN     = 3'd1,
        PH_OPT_HDR   = 3'd2,
        PH_DELTA_EXT = 3'd3,
        PH_LEN_EXT   = 3'd4,
        PH_VALUE     = 3'd5,
        PH_PAYLOAD   = 3'd6
    } t_phase;

    // byte class codes
    localparam logic [2:0] CLS_HEADER     = 3'd0;
    localparam logic [2:0] CLS_TOKEN      = 3'd1;
    localparam logic [2:0] CLS_OPT_HDR    = 3'd2;
    localparam logic [2:0] CLS_DELTA_EXT  = 3'd3;
    localparam logic [2:0] CLS_LEN_EXT    = 3'd4;
    localparam logic [2:0] CLS_VALUE      = 3'd5;
    localparam logic [2:0] CLS_MARKER     = 3'd6;
    localparam logic [2:0] CLS_PAYLOAD    = 3'd7;

    localparam logic [3:0]  NIB_EXT_ONE    = 4'd13;
    localparam logic [3:0]  NIB_EXT_TWO    = 4'd14;
    localparam logic [15:0] EXT_ONE_OFFSET = 16'd13;
    localparam logic [15:0] EXT_TWO_OFFSET = 16'd269;
    localparam logic [7:0]  MARKER_BYTE    = 8'hFF;
    localparam logic [3:0]  TOKEN_MAX      = 4'd8;
    localparam logic [7:0]  OPT_TOTAL_MAX  = 8'hFF;
    localparam logic [1:0]  HDR_LAST_POS   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic        option_ready;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  option_total;
        logic [3:0]  token_count;
        logic        truncated;
        logic        end_of_message;
    } t_out_word;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  header_position;
        logic [3:0]  token_left;
        logic [3:0]  token_size;
        logic [3:0]  pending_delta_nibble;
        logic [3:0]  pending_length_nibble;
        logic [7:0]  extension_high_byte;
        logic [1:0]  extension_bytes_left;
        logic [15:0] running_number;
        logic [15:0] current_length;
        logic [15:0] value_left;
        logic [7:0]  options_seen;
    } t_state;

endpackage

[hdl/cmsp_step.sv]
module cmsp_step
    import cmsp_pkg::*;
(
    input  t_state    i_state,
    input  t_in_word  i_word,
    output t_state    o_state,
    output t_out_word o_word
);

    t_state      n;
    logic [2:0]  cls;
    logic        ready;
    logic        do_after_delta;
    logic        do_finish;
    logic [15:0] fin_len;
    logic [15:0] ext_lo;
    logic [15:0] ext_hi;
    logic [3:0]  nib;
    logic        trunc;

    always_comb begin
        n              = i_state;
        cls            = CLS_HEADER;
        ready          = 1'b0;
        do_after_delta = 1'b0;
        do_finish      = 1'b0;
        fin_len        = 16'd0;
        nib            = i_word.in_byte[3:0];
        ext_lo         = {8'h00, i_word.in_byte} + EXT_ONE_OFFSET;
        ext_hi         = {i_state.extension_high_byte, i_word.in_byte} + EXT_TWO_OFFSET;

        unique case (i_state.phase)
            PH_HEADER: begin
                cls = CLS_HEADER;
                if (i_state.header_position == 2'd0) begin
                    n.token_size = (nib != 4'd0 && nib <= TOKEN_MAX) ? nib : 4'd0;
                end
                if (i_state.header_position == HDR_LAST_POS) begin
                    n.header_position = 2'd0;
                    n.token_left      = n.token_size;
                    n.phase           = (n.token_size != 4'd0) ? PH_TOKEN : PH_OPT_HDR;
                end else begin
                    n.header_position = i_state.header_position + 2'd1;
                end
            end
            PH_TOKEN: begin
                cls = CLS_TOKEN;
                if (i_state.token_left != 4'd0) begin
                    n.token_left = i_state.token_left - 4'd1;
                end
                if (n.token_left == 4'd0) begin
                    n.phase = PH_OPT_HDR;
                end
            end
            PH_OPT_HDR: begin
                if (i_word.in_byte == MARKER_BYTE) begin
                    cls     = CLS_MARKER;
                    n.phase = PH_PAYLOAD;
                end else begin
                    cls                     = CLS_OPT_HDR;
                    n.pending_delta_nibble  = i_word.in_byte[7:4];
                    n.pending_length_nibble = nib;
                    if (i_word.in_byte[7:4] == NIB_EXT_ONE
                            || i_word.in_byte[7:4] == NIB_EXT_TWO) begin
                        n.extension_bytes_left =
                            (i_word.in_byte[7:4] == NIB_EXT_TWO) ? 2'd2 : 2'd1;
                        n.phase = PH_DELTA_EXT;
                    end else begin
                        n.running_number = i_state.running_number
                                         + {12'h000, i_word.in_byte[7:4]};
                        do_after_delta   = 1'b1;
                    end
                end
            end
            PH_DELTA_EXT: begin
                cls = CLS_DELTA_EXT;
                if (i_state.extension_bytes_left >= 2'd2) begin
                    n.extension_high_byte  = i_word.in_byte;
                    n.extension_bytes_left = 2'd1;
                end else begin
                    n.extension_bytes_left = 2'd0;
                    n.running_number = i_state.running_number
                        + ((i_state.pending_delta_nibble == NIB_EXT_TWO) ? ext_hi : ext_lo);
                    do_after_delta = 1'b1;
                end
            end
            PH_LEN_EXT: begin
                cls = CLS_LEN_EXT;
                if (i_state.extension_bytes_left >= 2'd2) begin
                    n.extension_high_byte  = i_word.in_byte;
                    n.extension_bytes_left = 2'd1;
                end else begin
                    n.extension_bytes_left = 2'd0;
                    do_finish = 1'b1;
                    fin_len   = (i_state.pending_length_nibble == NIB_EXT_TWO) ? ext_hi
                                                                               : ext_lo;
                end
            end
            PH_VALUE: begin
                cls = CLS_VALUE;
                if (i_state.value_left != 16'd0) begin
                    n.value_left = i_state.value_left - 16'd1;
                end
                if (n.value_left == 16'd0) begin
                    n.phase = PH_OPT_HDR;
                end
            end
            default: begin
                cls     = CLS_PAYLOAD;
                n.phase = PH_PAYLOAD;
            end
        endcase

        // length nibble either needs extension bytes or closes the option here
        if (do_after_delta) begin
            if (n.pending_length_nibble == NIB_EXT_ONE
                    || n.pending_length_nibble == NIB_EXT_TWO) begin
                n.extension_bytes_left =
                    (n.pending_length_nibble == NIB_EXT_TWO) ? 2'd2 : 2'd1;
                n.phase = PH_LEN_EXT;
            end else begin
                do_finish = 1'b1;
                fin_len   = {12'h000, n.pending_length_nibble};
            end
        end

        if (do_finish) begin
            ready            = 1'b1;
            n.current_length = fin_len;
            n.value_left     = fin_len;
            if (n.options_seen != OPT_TOTAL_MAX) begin
                n.options_seen = n.options_seen + 8'd1;
            end
            n.phase = (fin_len != 16'd0) ? PH_VALUE : PH_OPT_HDR;
        end

        trunc = i_word.last_byte && n.phase != PH_OPT_HDR && n.phase != PH_PAYLOAD;

        o_word.byte_class     = cls;
        o_word.option_ready   = ready;
        o_word.option_number  = n.running_number;
        o_word.option_length  = n.current_length;
        o_word.option_total   = n.options_seen;
        o_word.token_count    = n.token_size;
        o_word.truncated      = trunc;
        o_word.end_of_message = i_word.last_byte;

        // message done: back to the reset state
        if (i_word.last_byte) begin
            n = '0;
        end
        o_state = n;
    end

endmodule

[hdl/coap_message_stream_parser.sv]
// An accepted byte's result word is registered and shows on o_out_data next cycle.
// One byte per cycle while the sink keeps up; the parse state and the decode
// of each byte sit between the state register and a single output register.
// A byte is taken while a result waits, provided the sink takes it that cycle.
// Reset (synchronous, active low) returns the parser to the header phase and
// empties the output register; state also clears after each last byte.
module coap_message_stream_parser
    import cmsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out_data;
    t_out_word step_word;
    logic      accept;

    cmsp_step u_step (
        .i_state (r_state),
        .i_word  (i_in_data),
        .o_state (n_state),
        .o_word  (step_word)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= step_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/cmsp_checker.sv]
module cmsp_checker
    import cmsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // every accepted byte yields a result word next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted byte produced no result word");

    // truncation is only ever flagged on the last byte
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.truncated |-> o_out_data.end_of_message)
        else $error("truncated without end of message");

    // an option completes only on an option header or extension byte
    a_opt_ready_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.option_ready |->
            (o_out_data.byte_class == CLS_OPT_HDR
             || o_out_data.byte_class == CLS_DELTA_EXT
             || o_out_data.byte_class == CLS_LEN_EXT))
        else $error("option_ready on wrong byte class");

    // token length never exceeds eight
    a_token_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.token_count <= TOKEN_MAX)
        else $error("token_count out of range");

endmodule

bind coap_message_stream_parser cmsp_checker u_cmsp_checker (.*);

[test/coap_message_stream_parser_test.sv]
module coap_message_stream_parser_test
    import cmsp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES       = 800;
    localparam int SATURATION_OPTIONS = 260;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int REPORT_LIMIT       = 40;

    typedef enum int {SINK_FREE, SINK_LIGHT, SINK_PERIODIC, SINK_HEAVY} t_sink_mode;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    coap_message_stream_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser state as the byte stream is classified
    t_phase      ph;
    logic [1:0]  hdr_pos;
    logic [3:0]  tok_left, tok_len, dnib, lnib;
    logic [7:0]  ext_hi;
    logic [1:0]  ext_left;
    logic [15:0] opt_num, opt_len, val_left;
    logic [7:0]  opt_cnt;

    t_out_word   awaited_words[$];
    t_out_word   head_word;
    logic [7:0]  frame[$];

    int errors         = 0;
    int results_seen   = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int frames_damaged = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int idle_enable    = 1;
    int sink_hold      = 0;
    t_sink_mode sink_mode = SINK_FREE;

    function automatic void clear_parse_state();
        ph       = PH_HEADER;
        hdr_pos  = '0;
        tok_left = '0;
        tok_len  = '0;
        dnib     = '0;
        lnib     = '0;
        ext_hi   = '0;
        ext_left = '0;
        opt_num  = '0;
        opt_len  = '0;
        val_left = '0;
        opt_cnt  = '0;
    endfunction

    function automatic logic [15:0] ext_sum(input logic [3:0] nib, input logic [7:0] b);
        if (nib == NIB_EXT_TWO)
            return {ext_hi, b} + EXT_TWO_OFFSET;
        return {8'd0, b} + EXT_ONE_OFFSET;
    endfunction

    function automatic void close_option(input logic [15:0] len);
        opt_len  = len;
        val_left = len;
        if (opt_cnt != OPT_TOTAL_MAX)
            opt_cnt++;
        if (len != 16'd0)
            ph = PH_VALUE;
        else
            ph = PH_OPT_HDR;
    endfunction

    // returns 1 when the length is known without extension bytes
    function automatic logic take_length_nibble();
        if (lnib == NIB_EXT_ONE || lnib == NIB_EXT_TWO) begin
            ext_left = (lnib == NIB_EXT_TWO) ? 2'd2 : 2'd1;
            ph = PH_LEN_EXT;
            return 1'b0;
        end
        close_option({12'd0, lnib});
        return 1'b1;
    endfunction

    function automatic t_out_word classify_byte(input t_in_word w);
        t_out_word  r;
        logic [7:0] b;
        b = w.in_byte;
        r = '0;
        case (ph)
            PH_HEADER: begin
                r.byte_class = CLS_HEADER;
                if (hdr_pos == 2'd0)
                    tok_len = (b[3:0] != 4'd0 && b[3:0] <= TOKEN_MAX) ? b[3:0] : 4'd0;
                if (hdr_pos == HDR_LAST_POS) begin
                    hdr_pos  = 2'd0;
                    tok_left = tok_len;
                    if (tok_len != 4'd0)
                        ph = PH_TOKEN;
                    else
                        ph = PH_OPT_HDR;
                end else begin
                    hdr_pos++;
                end
            end
            PH_TOKEN: begin
                r.byte_class = CLS_TOKEN;
                if (tok_left != 4'd0)
                    tok_left--;
                if (tok_left == 4'd0)
                    ph = PH_OPT_HDR;
            end
            PH_OPT_HDR: begin
                if (b == MARKER_BYTE) begin
                    r.byte_class = CLS_MARKER;
                    ph = PH_PAYLOAD;
                end else begin
                    r.byte_class = CLS_OPT_HDR;
                    dnib = b[7:4];
                    lnib = b[3:0];
                    if (dnib == NIB_EXT_ONE || dnib == NIB_EXT_TWO) begin
                        ext_left = (dnib == NIB_EXT_TWO) ? 2'd2 : 2'd1;
                        ph = PH_DELTA_EXT;
                    end else begin
                        opt_num = opt_num + {12'd0, dnib};
                        r.option_ready = take_length_nibble();
                    end
                end
            end
            PH_DELTA_EXT: begin
                r.byte_class = CLS_DELTA_EXT;
                if (ext_left >= 2'd2) begin
                    ext_hi   = b;
                    ext_left = 2'd1;
                end else begin
                    ext_left = 2'd0;
                    opt_num  = opt_num + ext_sum(dnib, b);
                    r.option_ready = take_length_nibble();
                end
            end
            PH_LEN_EXT: begin
                r.byte_class = CLS_LEN_EXT;
                if (ext_left >= 2'd2) begin
                    ext_hi   = b;
                    ext_left = 2'd1;
                end else begin
                    ext_left = 2'd0;
                    close_option(ext_sum(lnib, b));
                    r.option_ready = 1'b1;
                end
            end
            PH_VALUE: begin
                r.byte_class = CLS_VALUE;
                if (val_left != 16'd0)
                    val_left--;
                if (val_left == 16'd0)
                    ph = PH_OPT_HDR;
            end
            default: begin
                r.byte_class = CLS_PAYLOAD;
                ph = PH_PAYLOAD;
            end
        endcase
        r.truncated      = w.last_byte && ph != PH_OPT_HDR && ph != PH_PAYLOAD;
        r.option_number  = opt_num;
        r.option_length  = opt_len;
        r.option_total   = opt_cnt;
        r.token_count    = tok_len;
        r.end_of_message = w.last_byte;
        if (w.last_byte)
            clear_parse_state();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                      results_seen, name, got, want));
    endtask

    // one byte per call; entered and left at a falling edge
    task automatic send_word(input logic [7:0] b, input logic last);
        t_in_word w;
        int       gap;
        w.in_byte   = b;
        w.last_byte = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = idle_enable ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_words.push_back(classify_byte(w));
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_word(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    // nibble of one option field, with its extension and decoded value
    function automatic logic [3:0] pick_nibble(input bit for_length,
            output logic [15:0] value, output logic [15:0] ext, output int ext_n);
        int         k;
        logic [3:0] nib;
        k     = $urandom_range(0, 9);
        ext_n = 0;
        ext   = '0;
        if (k <= 5) begin
            nib   = for_length ? 4'($urandom_range(0, 6)) : 4'($urandom_range(0, 12));
            value = {12'd0, nib};
        end else if (k <= 7) begin
            nib   = NIB_EXT_ONE;
            ext_n = 1;
            ext   = for_length ? 16'($urandom_range(0, 24)) : 16'($urandom_range(0, 255));
            value = ext + EXT_ONE_OFFSET;
        end else if (k == 8) begin
            nib   = NIB_EXT_TWO;
            ext_n = 2;
            if (!for_length)
                ext = 16'($urandom);
            else if ($urandom_range(0, 7) == 0)
                ext = 16'h0000;
            else
                ext = {8'hFE, 8'($urandom_range(8'hF3, 8'hFF))};  // wraps to 0..12
            value = ext + EXT_TWO_OFFSET;
        end else begin
            nib   = 4'd15;
            value = {12'd0, nib};
        end
        return nib;
    endfunction

    function automatic void build_random_frame();
        int          pick, cut, dext_n, lext_n;
        logic [3:0]  tkl, dn, ln;
        logic [15:0] dval, lval, dext, lext;
        frame.delete();
        pick = $urandom_range(0, 11);
        tkl  = (pick <= 8) ? 4'(pick) : 4'($urandom_range(9, 15));
        frame.push_back({4'($urandom), tkl});
        repeat (3) frame.push_back(8'($urandom));
        if (tkl != 4'd0 && tkl <= TOKEN_MAX)
            repeat (tkl) frame.push_back(8'($urandom));
        repeat ($urandom_range(0, 6)) begin
            dn = pick_nibble(1'b0, dval, dext, dext_n);
            ln = pick_nibble(1'b1, lval, lext, lext_n);
            // both nibbles 15 would read as the payload marker
            if (dn == 4'd15 && ln == 4'd15) begin
                ln     = 4'd0;
                lval   = '0;
                lext_n = 0;
            end
            frame.push_back({dn, ln});
            if (dext_n == 2) frame.push_back(dext[15:8]);
            if (dext_n >= 1) frame.push_back(dext[7:0]);
            if (lext_n == 2) frame.push_back(lext[15:8]);
            if (lext_n >= 1) frame.push_back(lext[7:0]);
            repeat (lval) frame.push_back(8'($urandom));
        end
        if ($urandom_range(0, 1) == 1) begin
            frame.push_back(MARKER_BYTE);
            repeat ($urandom_range(0, 8)) frame.push_back(8'($urandom));
        end
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
                void'(frame.pop_back());
            frames_damaged++;
        end else if (pick == 3) begin
            frame.delete();
            repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
            frames_damaged++;
        end
    endfunction

    task automatic test_directed();
        idle_enable = 1;
        // token nibble 15 gives no token; clean end at an option boundary
        frame = '{8'h4F, 8'h00, 8'h00, 8'h00};
        send_frame();
        // one-byte and two-byte delta extensions (second one wraps), literal 15 delta,
        // two-byte length extension wrapping to zero, then end inside a length extension
        frame = '{8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hAB, 8'hD0, 8'hFF, 8'hE1, 8'hFF,
                  8'hFF, 8'h00, 8'hF0, 8'h0E, 8'hFE, 8'hF3, 8'h0D};
        send_frame();
        // end straight after the payload marker
        frame = '{8'h40, 8'h00, 8'h00, 8'h00, MARKER_BYTE};
        send_frame();
        // end inside the fixed header
        frame = '{8'h58, 8'h00};
        send_frame();
    endtask

    task automatic test_option_count_saturation();
        idle_enable = 1;
        frame = '{8'h40, 8'h00, 8'h00, 8'h00};
        repeat (SATURATION_OPTIONS) frame.push_back({4'($urandom_range(0, 12)), 4'd0});
        send_frame();
    endtask

    task automatic test_random_frames();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            build_random_frame();
            send_frame();
        end
    endtask

    // sink side: modes held for a while, one of them never stalls
    always @(negedge clk) begin
        if (sink_hold == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_hold = $urandom_range(20, 120);
        end
        sink_hold--;
        case (sink_mode)
            SINK_FREE:     out_ready <= 1'b1;
            SINK_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
            SINK_PERIODIC: out_ready <= (sink_hold % 3 != 0);
            default:       out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_words.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing awaited",
                                          results_seen));
            end else begin
                head_word = awaited_words.pop_front();
                check_field("byte_class", out_data.byte_class, head_word.byte_class);
                check_field("option_ready", out_data.option_ready, head_word.option_ready);
                check_field("option_number", out_data.option_number,
                            head_word.option_number);
                check_field("option_length", out_data.option_length,
                            head_word.option_length);
                check_field("option_total", out_data.option_total, head_word.option_total);
                check_field("token_count", out_data.token_count, head_word.token_count);
                check_field("truncated", out_data.truncated, head_word.truncated);
                check_field("end_of_message", out_data.end_of_message,
                            head_word.end_of_message);
            end
            results_seen++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still awaited",
                 cycle_count, awaited_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        clear_parse_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_option_count_saturation();
        test_random_frames();

        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Parsed %0d bytes in %0d messages (%0d cut short or noise).",
                 bytes_sent, frames_sent, frames_damaged);
        $display("Checked %0d result words, %0d mismatches.", results_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
hdl/cmsp_pkg.sv
hdl/cmsp_step.sv
hdl/coap_message_stream_parser.sv
hdl/cmsp_checker.sv
test/coap_message_stream_parser_test.sv
